@@ rtl/core/tcd_pkg.sv @@
`default_nettype none

package tcd_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 800;
   localparam int DISPLAY_HEIGHT_DEF = 480;
   localparam int MAX_POINTS_DEF     = 10;

   localparam logic [11:0] COORD_INVALID = 12'hFFF;

   localparam logic [1:0] KIND_POINT   = 2'd0;
   localparam logic [1:0] KIND_CLEARED = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;

   localparam logic [3:0] ROT_NONE      = 4'd0;
   localparam logic [3:0] ROT_LRTB      = 4'd1;
   localparam logic [3:0] ROT_LRBT      = 4'd2;
   localparam logic [3:0] ROT_RLTB      = 4'd3;
   localparam logic [3:0] ROT_RLBT      = 4'd4;
   localparam logic [3:0] ROT_TBLR      = 4'd5;
   localparam logic [3:0] ROT_BTLR      = 4'd6;
   localparam logic [3:0] ROT_TBRL      = 4'd7;
   localparam logic [3:0] ROT_BTRL      = 4'd8;
   localparam logic [3:0] ROT_SWAP_INVV = 4'd9;
   localparam logic [3:0] ROT_SWAP_INVH = 4'd10;

   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic [3:0]  point_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] raw_x;
      logic [11:0] raw_y;
      logic [3:0]  index;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    pop;
   } pop_type;

   typedef struct packed {
      logic    full;
      logic    empty;
      cmd_type head;
   } queue_status_type;

endpackage

`default_nettype wire

@@ rtl/core/tcd_front.sv @@
`default_nettype none

module tcd_front #(
   parameter int MAX_POINTS = tcd_pkg::MAX_POINTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcd_pkg::req_type req_data,
   input  wire logic             queue_full,
   output tcd_pkg::push_type     push_out
);

   localparam logic [3:0] MaxPointsC = 4'(MAX_POINTS);

   typedef enum logic [1:0] {
      POS_X_HIGH,
      POS_X_LOW,
      POS_Y_HIGH,
      POS_Y_LOW
   } pos_type;

   logic [3:0]  expected_ff, expected_in;
   logic [3:0]  next_ff, next_in;
   pos_type     pos_ff, pos_in;
   logic [3:0]  xh_ff, xh_in;
   logic [7:0]  xl_ff, xl_in;
   logic [3:0]  yh_ff, yh_in;

   logic        accept;
   logic [3:0]  count_n;
   logic [11:0] x_full;
   logic [11:0] y_full;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign count_n   = (req_data.data_byte[3:0] > MaxPointsC) ? MaxPointsC
                                                             : req_data.data_byte[3:0];
   assign x_full    = {xh_ff, xl_ff};
   assign y_full    = {yh_ff, req_data.data_byte};

   always_comb begin
      expected_in = expected_ff;
      next_in     = next_ff;
      pos_in      = pos_ff;
      xh_in       = xh_ff;
      xl_in       = xl_ff;
      yh_in       = yh_ff;
      push_out    = '0;
      if (accept) begin
         if (req_data.is_count) begin
            expected_in = count_n;
            next_in     = 4'd0;
            pos_in      = POS_X_HIGH;
            if (count_n == 4'd0) begin
               push_out.push     = 1'b1;
               push_out.cmd.kind = tcd_pkg::KIND_EMPTY;
               push_out.cmd.last = 1'b1;
            end
         end else if (next_ff < expected_ff) begin
            unique case (pos_ff)
               POS_X_HIGH: begin
                  xh_in  = req_data.data_byte[3:0];
                  pos_in = POS_X_LOW;
               end
               POS_X_LOW: begin
                  xl_in  = req_data.data_byte;
                  pos_in = POS_Y_HIGH;
               end
               POS_Y_HIGH: begin
                  yh_in  = req_data.data_byte[3:0];
                  pos_in = POS_Y_LOW;
               end
               POS_Y_LOW: begin
                  pos_in             = POS_X_HIGH;
                  push_out.push      = 1'b1;
                  push_out.cmd.index = next_ff;
                  if (x_full == tcd_pkg::COORD_INVALID ||
                      y_full == tcd_pkg::COORD_INVALID) begin
                     expected_in       = 4'd0;
                     next_in           = 4'd0;
                     push_out.cmd.kind = tcd_pkg::KIND_CLEARED;
                     push_out.cmd.last = 1'b1;
                  end else begin
                     next_in            = next_ff + 4'd1;
                     push_out.cmd.kind  = tcd_pkg::KIND_POINT;
                     push_out.cmd.raw_x = x_full;
                     push_out.cmd.raw_y = y_full;
                     push_out.cmd.last  = (next_ff + 4'd1 == expected_ff);
                  end
               end
               default: pos_in = POS_X_HIGH;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 4'd0;
         next_ff     <= 4'd0;
         pos_ff      <= POS_X_HIGH;
      end else begin
         expected_ff <= expected_in;
         next_ff     <= next_in;
         pos_ff      <= pos_in;
      end
      xh_ff <= xh_in;
      xl_ff <= xl_in;
      yh_ff <= yh_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/tcd_queue.sv @@
`default_nettype none

module tcd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcd_pkg::push_type push_in,
   input  wire tcd_pkg::pop_type  pop_in,
   output tcd_pkg::queue_status_type status
);

   localparam int AW = tcd_pkg::QUEUE_AW;

   tcd_pkg::cmd_type mem_ff [tcd_pkg::QUEUE_DEPTH];

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign status.full  = (count_ff == (AW+1)'(tcd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = mem_ff[rd_ptr_ff];

   assign do_push = push_in.push && !status.full;
   assign do_pop  = pop_in.pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tcd_back.sv @@
`default_nettype none

module tcd_back #(
   parameter int DISPLAY_WIDTH  = tcd_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = tcd_pkg::DISPLAY_HEIGHT_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [3:0]                 rotation_mode,
   input  wire tcd_pkg::queue_status_type  status,
   output tcd_pkg::pop_type                pop_out,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output tcd_pkg::rsp_type                rsp_data
);

   localparam logic [15:0] WidthMax  = 16'(DISPLAY_WIDTH - 1);
   localparam logic [15:0] HeightMax = 16'(DISPLAY_HEIGHT - 1);

   logic             rsp_valid_ff, rsp_valid_in;
   tcd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             take;
   logic [15:0]      px;
   logic [15:0]      py;
   logic [15:0]      rx;
   logic [15:0]      ry;

   assign take        = !status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop_out.pop = take;
   assign px          = {4'd0, status.head.raw_x};
   assign py          = {4'd0, status.head.raw_y};

   always_comb begin
      rx = px;
      ry = py;
      unique case (rotation_mode)
         tcd_pkg::ROT_LRBT: ry = HeightMax - py;
         tcd_pkg::ROT_RLTB: rx = WidthMax - px;
         tcd_pkg::ROT_RLBT: begin
            rx = WidthMax - px;
            ry = HeightMax - py;
         end
         tcd_pkg::ROT_TBLR: begin
            rx = py;
            ry = px;
         end
         tcd_pkg::ROT_BTLR: begin
            rx = py;
            ry = WidthMax - px;
         end
         tcd_pkg::ROT_TBRL: begin
            rx = HeightMax - py;
            ry = px;
         end
         tcd_pkg::ROT_BTRL: begin
            rx = HeightMax - py;
            ry = WidthMax - px;
         end
         tcd_pkg::ROT_SWAP_INVV: begin
            rx = py;
            ry = HeightMax - px;
         end
         tcd_pkg::ROT_SWAP_INVH: begin
            rx = WidthMax - py;
            ry = px;
         end
         default: begin
            rx = px;
            ry = py;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = status.head.kind;
         rsp_data_in.point_index = status.head.index;
         rsp_data_in.last        = status.head.last;
         if (status.head.kind == tcd_pkg::KIND_POINT) begin
            rsp_data_in.point_x = rx;
            rsp_data_in.point_y = ry;
         end else begin
            rsp_data_in.point_x = 16'd0;
            rsp_data_in.point_y = 16'd0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/touch_report_decoder_core.sv @@
// a result reaches rsp through its queue entry and then the output register once its byte is accepted
// throughput: one byte per cycle; the front stalls only when the two-entry queue is full
// the back drains one queued command per cycle into the output register unless rsp_stall holds it full
// reset: synchronous, active high; clears report state, queue and output valid,
// and sets rotation_mode to 0
`default_nettype none

module touch_report_decoder_core #(
   parameter int DISPLAY_WIDTH  = tcd_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = tcd_pkg::DISPLAY_HEIGHT_DEF,
   parameter int MAX_POINTS     = tcd_pkg::MAX_POINTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tcd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [3:0]       csr_data
);

   logic [3:0]                rotation_ff, rotation_in;
   tcd_pkg::push_type         push;
   tcd_pkg::pop_type          pop;
   tcd_pkg::queue_status_type status;

   assign csr_ready   = 1'b1;
   assign rotation_in = (csr_valid && csr_ready) ? csr_data : rotation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= tcd_pkg::ROT_NONE;
      end else begin
         rotation_ff <= rotation_in;
      end
   end

   tcd_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (status.full),
      .push_out   (push)
   );

   tcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop_in  (pop),
      .status  (status)
   );

   tcd_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .rotation_mode (rotation_ff),
      .status        (status),
      .pop_out       (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !status.full)
      else $error("command pushed into full queue");

   a_non_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != tcd_pkg::KIND_POINT |->
         rsp_data.point_x == 16'd0 && rsp_data.point_y == 16'd0 && rsp_data.last)
      else $error("cleared or empty item carries coordinates or lacks last");

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      pop.pop |=> rsp_valid)
      else $error("popped command did not reach the output register");
`endif

endmodule

`default_nettype wire

@@ tb/tb_touch_report_decoder_core.sv @@
`timescale 1ns / 1ps

class touch_point_tracker;
   logic [3:0] rot_mode    = tcd_pkg::ROT_NONE;
   logic [3:0] want_points = '0;
   logic [3:0] point_no    = '0;
   logic [1:0] byte_no     = '0;
   logic [3:0] x_high      = '0;
   logic [7:0] x_low       = '0;
   logic [3:0] y_high      = '0;
   int errors = 0;
   tcd_pkg::rsp_type points_due[$];

   function logic [15:0] mirror_w(logic [15:0] v);
      return 16'(tcd_pkg::DISPLAY_WIDTH_DEF - 1) - v;
   endfunction

   function logic [15:0] mirror_h(logic [15:0] v);
      return 16'(tcd_pkg::DISPLAY_HEIGHT_DEF - 1) - v;
   endfunction

   function void set_mode(logic [3:0] m);
      rot_mode = m;
   endfunction

   function void note_byte(tcd_pkg::req_type item);
      tcd_pkg::rsp_type r;
      logic [3:0] n;
      logic [15:0] px, py;
      r = '0;
      if (item.is_count) begin
         n = item.data_byte[3:0];
         if (n > tcd_pkg::MAX_POINTS_DEF) n = 4'(tcd_pkg::MAX_POINTS_DEF);
         want_points = n;
         point_no = '0;
         byte_no = '0;
         if (n == 0) begin
            r.kind = tcd_pkg::KIND_EMPTY;
            r.last = 1'b1;
            points_due.push_back(r);
         end
         return;
      end
      // coordinate bytes outside a report are dropped
      if (point_no >= want_points) return;
      case (byte_no)
         2'd0: begin
            x_high = item.data_byte[3:0];
            byte_no = 2'd1;
         end
         2'd1: begin
            x_low = item.data_byte;
            byte_no = 2'd2;
         end
         2'd2: begin
            y_high = item.data_byte[3:0];
            byte_no = 2'd3;
         end
         default: begin
            byte_no = 2'd0;
            px = {4'h0, x_high, x_low};
            py = {4'h0, y_high, item.data_byte};
            r.point_index = point_no;
            if (px[11:0] == tcd_pkg::COORD_INVALID || py[11:0] == tcd_pkg::COORD_INVALID) begin
               want_points = '0;
               point_no = '0;
               r.kind = tcd_pkg::KIND_CLEARED;
               r.last = 1'b1;
            end else begin
               r.kind = tcd_pkg::KIND_POINT;
               r.point_x = px;
               r.point_y = py;
               case (rot_mode)
                  tcd_pkg::ROT_LRBT: r.point_y = mirror_h(py);
                  tcd_pkg::ROT_RLTB: r.point_x = mirror_w(px);
                  tcd_pkg::ROT_RLBT: begin
                     r.point_x = mirror_w(px);
                     r.point_y = mirror_h(py);
                  end
                  tcd_pkg::ROT_TBLR: begin
                     r.point_x = py;
                     r.point_y = px;
                  end
                  tcd_pkg::ROT_BTLR: begin
                     r.point_x = py;
                     r.point_y = mirror_w(px);
                  end
                  tcd_pkg::ROT_TBRL: begin
                     r.point_x = mirror_h(py);
                     r.point_y = px;
                  end
                  tcd_pkg::ROT_BTRL: begin
                     r.point_x = mirror_h(py);
                     r.point_y = mirror_w(px);
                  end
                  tcd_pkg::ROT_SWAP_INVV: begin
                     r.point_x = py;
                     r.point_y = mirror_h(px);
                  end
                  tcd_pkg::ROT_SWAP_INVH: begin
                     r.point_x = mirror_w(py);
                     r.point_y = px;
                  end
                  default: ;
               endcase
               r.last = ({1'b0, point_no} + 5'd1 == {1'b0, want_points});
               point_no = point_no + 4'd1;
            end
            points_due.push_back(r);
         end
      endcase
   endfunction

   task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= 100)
         $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
   endtask

   task check_point(tcd_pkg::rsp_type got);
      tcd_pkg::rsp_type want;
      if (points_due.size() == 0) begin
         report("unexpected item kind", 16'(got.kind), 16'h0);
         return;
      end
      want = points_due.pop_front();
      if (got.kind != want.kind) report("kind", 16'(got.kind), 16'(want.kind));
      if (got.point_x != want.point_x) report("point_x", got.point_x, want.point_x);
      if (got.point_y != want.point_y) report("point_y", got.point_y, want.point_y);
      if (got.point_index != want.point_index)
         report("point_index", 16'(got.point_index), 16'(want.point_index));
      if (got.last != want.last) report("last", 16'(got.last), 16'(want.last));
   endtask
endclass

module tb_touch_report_decoder_core;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 53;
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tcd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tcd_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_data = '0;

   int send_pct = 0;
   int recv_pct = 0;
   int cycle_count = 0;
   touch_point_tracker points = new;
   tcd_pkg::req_type byte_stream[$];

   touch_report_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_touch_report_decoder_core: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) points.check_point(rsp_data);
   end

   task add_byte(logic [7:0] b, logic is_count);
      tcd_pkg::req_type item;
      item.data_byte = b;
      item.is_count = is_count;
      byte_stream.push_back(item);
   endtask

   function logic [11:0] pick_coord();
      int r;
      r = $urandom_range(29);
      if (r == 0) return tcd_pkg::COORD_INVALID;
      if (r == 1) return 12'h000;
      if (r == 2) return 12'hFFE;
      return 12'($urandom);
   endfunction

   // count byte plus four bytes per point, sometimes cut short
   task add_report();
      int r, n, pts, cut, k;
      logic [11:0] x, y;
      r = $urandom_range(99);
      if (r < 10) n = 0;
      else if (r < 75) n = $urandom_range(4, 1);
      else n = $urandom_range(15, 5);
      add_byte({4'($urandom), 4'(n)}, 1'b1);
      pts = (n > tcd_pkg::MAX_POINTS_DEF) ? tcd_pkg::MAX_POINTS_DEF : n;
      cut = ($urandom_range(9) == 0) ? $urandom_range(pts * 4) : pts * 4;
      k = 0;
      for (int p = 0; p < pts; p++) begin
         x = pick_coord();
         y = pick_coord();
         if (k < cut) add_byte({4'($urandom), x[11:8]}, 1'b0);
         k++;
         if (k < cut) add_byte(x[7:0], 1'b0);
         k++;
         if (k < cut) add_byte({4'($urandom), y[11:8]}, 1'b0);
         k++;
         if (k < cut) add_byte(y[7:0], 1'b0);
         k++;
      end
   endtask

   task send_all();
      tcd_pkg::req_type item;
      while (byte_stream.size() != 0) begin
         item = byte_stream.pop_front();
         while ($urandom_range(99) < send_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid = 1'b1;
         req_data = item;
         do @(posedge clock); while (req_stall);
         points.note_byte(item);
         @(negedge clock);
      end
      req_valid = 1'b0;
   endtask

   task wait_drained();
      while (points.points_due.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task write_mode(logic [3:0] m);
      csr_valid = 1'b1;
      csr_data = m;
      do @(posedge clock); while (!csr_ready);
      points.set_mode(m);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task set_idle(int kind);
      send_pct = (kind == IDLE_SENDER) ? 88 : (kind == IDLE_BOTH) ? 34 : 0;
      recv_pct = (kind == IDLE_RECEIVER) ? 88 : (kind == IDLE_BOTH) ? 34 : 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed reports at the reset rotation
      set_idle(IDLE_NONE);
      add_byte(8'hAA, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'hF2, 1'b1);
      add_byte(8'hF0, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hF0, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h0F, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_byte(8'h0F, 1'b0);
      add_byte(8'hFE, 1'b0);
      add_byte(8'h01, 1'b1);
      add_byte(8'h0F, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h55, 1'b0);
      add_byte(8'h03, 1'b1);
      add_byte(8'h01, 1'b0);
      add_byte(8'h23, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'h01, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h12, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b0);
      send_all();
      wait_drained();

      // every rotation code once, idle pattern rotating across phases
      for (int ph = 0; ph < 16; ph++) begin
         write_mode(4'((ph * 7) % 16));
         set_idle(ph % 4);
         while (byte_stream.size() < PHASE_ITEMS) begin
            if ($urandom_range(99) < 12) add_byte(8'($urandom), ($urandom_range(7) == 0));
            else add_report();
         end
         send_all();
         wait_drained();
      end

      if (points.errors == 0)
         $display("tb_touch_report_decoder_core: clean");
      else
         $display("tb_touch_report_decoder_core: errors");
      $finish;
   end

endmodule
